FILE: rtl/rgbdith_pkg.sv
// Shared types, register indexes and the channel add-and-clamp helper
// for the RGB565/RGB555 error diffusion dither. No dependencies.
`default_nettype none

package rgbdith_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned CARRY_W  = 2;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_BYTES   = 2'd1;

   // pixel_format codes
   localparam logic FMT_RGB565 = 1'b0;
   localparam logic FMT_RGB555 = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              line_start;
   } pixel_type;

   // add the carried error and saturate at full scale
   function automatic logic [CHAN_W-1:0] add_sat(input logic [CHAN_W-1:0]  chan,
                                                 input logic [CARRY_W-1:0] carry);
      logic [CHAN_W:0] sum;
      sum = {1'b0, chan} + {{(CHAN_W+1-CARRY_W){1'b0}}, carry};
      return sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rgb_error_diffusion_to_rgb565_555.sv
// Path: input register, then result register, which drives rsp_valid.
// Throughput: one request per cycle while the output is not stalled; the per-channel
// carry add-and-clamp loop is combinational, so requests wait only on rsp_stall.
// Stalls: req_stall rises only while both registers hold requests and rsp_stall is high.
// Reset (synchronous, active high): clears both valid bits, the carries,
// pixel_format (RGB565) and swap_bytes (off).
`default_nettype none

module rgb_error_diffusion_to_rgb565_555 (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic [rgbdith_pkg::CHAN_W-1:0]         req_red_in,
   input  wire logic [rgbdith_pkg::CHAN_W-1:0]         req_green_in,
   input  wire logic [rgbdith_pkg::CHAN_W-1:0]         req_blue_in,
   input  wire logic                                   req_line_start,
   // result channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [rgbdith_pkg::WORD_W-1:0]         rsp_packed_pixel,
   // configuration write port
   input  wire logic                                   csr_write_enable,
   input  wire logic [rgbdith_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic                                   csr_wdata
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic pixel_format_ff, pixel_format_in;
   logic swap_bytes_ff,   swap_bytes_in;

   always_comb begin
      pixel_format_in = pixel_format_ff;
      swap_bytes_in   = swap_bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rgbdith_pkg::CSR_PIXEL_FORMAT: pixel_format_in = csr_wdata;
            rgbdith_pkg::CSR_SWAP_BYTES:   swap_bytes_in   = csr_wdata;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= rgbdith_pkg::FMT_RGB565;
         swap_bytes_ff   <= 1'b0;
      end else begin
         pixel_format_ff <= pixel_format_in;
         swap_bytes_ff   <= swap_bytes_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake: input register feeds the result register. The result
   // register loads whenever it is empty or being drained, so the
   // input register moves on every cycle unless the output is stuck.
   // ---------------------------------------------------------------
   logic                   in_valid_ff,  in_valid_in;
   rgbdith_pkg::pixel_type in_pixel_ff,  in_pixel_in;
   logic                   out_valid_ff, out_valid_in;
   logic [rgbdith_pkg::WORD_W-1:0] out_word_ff, out_word_in;

   logic out_load;   // result register takes a new word this cycle
   logic in_load;    // input register takes a new request this cycle

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_load || (in_valid_ff && !out_load);
      in_pixel_in = in_pixel_ff;
      if (in_load) begin
         in_pixel_in.red        = req_red_in;
         in_pixel_in.green      = req_green_in;
         in_pixel_in.blue       = req_blue_in;
         in_pixel_in.line_start = req_line_start;
      end
      // hold a stalled word; otherwise advance or empty
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   // ---------------------------------------------------------------
   // Dither datapath: add carried error, clamp, truncate, carry half
   // of the dropped bits, pack, optionally swap bytes.
   // ---------------------------------------------------------------
   logic [rgbdith_pkg::CARRY_W-1:0] red_carry_ff,   red_carry_in;
   logic [rgbdith_pkg::CARRY_W-1:0] green_carry_ff, green_carry_in;
   logic [rgbdith_pkg::CARRY_W-1:0] blue_carry_ff,  blue_carry_in;

   logic [rgbdith_pkg::CHAN_W-1:0] red_adj, green_adj, blue_adj;
   logic [rgbdith_pkg::WORD_W-1:0] packed_word;

   always_comb begin
      // a line start carries no error in
      if (in_pixel_ff.line_start) begin
         red_adj   = in_pixel_ff.red;
         green_adj = in_pixel_ff.green;
         blue_adj  = in_pixel_ff.blue;
      end else begin
         red_adj   = rgbdith_pkg::add_sat(in_pixel_ff.red,   red_carry_ff);
         green_adj = rgbdith_pkg::add_sat(in_pixel_ff.green, green_carry_ff);
         blue_adj  = rgbdith_pkg::add_sat(in_pixel_ff.blue,  blue_carry_ff);
      end

      if (pixel_format_ff == rgbdith_pkg::FMT_RGB555) begin
         packed_word     = {1'b0, red_adj[7:3], green_adj[7:3], blue_adj[7:3]};
         green_carry_in  = green_adj[2:1];
      end else begin
         packed_word     = {red_adj[7:3], green_adj[7:2], blue_adj[7:3]};
         green_carry_in  = {1'b0, green_adj[1]};
      end
      red_carry_in  = red_adj[2:1];
      blue_carry_in = blue_adj[2:1];

      if (swap_bytes_ff) begin
         out_word_in = {packed_word[7:0], packed_word[15:8]};
      end else begin
         out_word_in = packed_word;
      end
   end

   // carries advance only when a request actually moves to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         red_carry_ff   <= '0;
         green_carry_ff <= '0;
         blue_carry_ff  <= '0;
      end else if (out_load) begin
         red_carry_ff   <= red_carry_in;
         green_carry_ff <= green_carry_in;
         blue_carry_ff  <= blue_carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_pixel_ff <= in_pixel_in;
      if (out_load) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_packed_pixel = out_word_ff;

endmodule

`default_nettype wire

FILE: rtl/rgbdith_check.sv
// Port-level checks for rgb_error_diffusion_to_rgb565_555 and the bind
// that attaches them. Depends on rgbdith_pkg for widths.
`default_nettype none

module rgbdith_check (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [rgbdith_pkg::WORD_W-1:0]     rsp_packed_pixel
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_pixel))
      else $error("result word changed while stalled");

   // the request side only backs up when the result side is stuck
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while result side was free");

   // a fresh result must come from a request accepted before it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without a matching request");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind rgb_error_diffusion_to_rgb565_555 rgbdith_check u_rgbdith_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_packed_pixel (rsp_packed_pixel)
);

`default_nettype wire
